FILE: sv/crz_pkg.sv
package crz_pkg;

    localparam int COORD_BITS = 16;
    localparam int COLOR_BITS = 32;
    localparam int CFG_BITS   = 15;
    localparam int CFG_IDX_BITS = 1;
    // working width of the clip arithmetic: wide enough for any clipped product
    localparam int WORK_BITS  = 48;
    localparam int CNT_BITS   = $clog2(WORK_BITS + 1);
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DEC_BITS   = 20;
    localparam int OP_BITS    = 3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // clip operations, in the order they are tried
    localparam logic [OP_BITS-1:0] OP_TOP_1    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_TOP_2    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_BOTTOM_1 = 3'd2;
    localparam logic [OP_BITS-1:0] OP_BOTTOM_2 = 3'd3;
    localparam logic [OP_BITS-1:0] OP_LEFT_1   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_LEFT_2   = 3'd5;
    localparam logic [OP_BITS-1:0] OP_RIGHT_1  = 3'd6;
    localparam logic [OP_BITS-1:0] OP_RIGHT_2  = 3'd7;

    typedef enum logic [2:0] {
        MODE_VERT   = 3'd0,
        MODE_HORZ   = 3'd1,
        MODE_PFLAT  = 3'd2,
        MODE_PSTEEP = 3'd3,
        MODE_NFLAT  = 3'd4,
        MODE_NSTEEP = 3'd5
    } t_mode;

    typedef struct packed {
        logic               load_start;
        logic               op_start;
        logic               apply;
        logic               finish;
        logic               reject;
        logic               step;
        logic [OP_BITS-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic reject_cond;
        logic inside_cond;
        logic op_cond;
        logic md_done;
        logic out_free;
    } t_status;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WORK_BITS-1:0] v);
        logic signed [WORK_BITS-1:0] lim_hi;
        logic signed [WORK_BITS-1:0] lim_lo;
        lim_hi = WORK_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lim_lo = -lim_hi - WORK_BITS'(1);
        if (v > lim_hi) begin
            return lim_hi[COORD_BITS-1:0];
        end else if (v < lim_lo) begin
            return lim_lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

FILE: sv/crz_in_if.sv
interface crz_in_if import crz_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  finish_x;
    logic signed [COORD_BITS-1:0]  finish_y;
    logic [COLOR_BITS-1:0]         line_color;

    modport source (output valid, cmd, start_x, start_y, finish_x, finish_y, line_color,
                    input ready);
    modport sink (input valid, cmd, start_x, start_y, finish_x, finish_y, line_color,
                  output ready);
endinterface

FILE: sv/crz_out_if.sv
interface crz_out_if import crz_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          pixel_valid;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic [COLOR_BITS-1:0]         pixel_color;
    logic                          last_pixel;
    logic                          line_rejected;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    line_rejected, input ready);
    modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  line_rejected, output ready);
endinterface

FILE: sv/crz_muldiv.sv
// Serial a*b/d, truncating; zero divisor gives zero. One bit per cycle.
module crz_muldiv import crz_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WORK_BITS-1:0] i_a,
    input  logic signed [WORK_BITS-1:0] i_b,
    input  logic signed [WORK_BITS-1:0] i_d,
    output logic                        o_done,
    output logic signed [WORK_BITS-1:0] o_quot
);

    logic                   r_busy;
    logic                   r_div_phase;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [WORK_BITS-1:0]   r_acc;
    logic [WORK_BITS-1:0]   r_mcand;
    logic [WORK_BITS-1:0]   r_mplier;
    logic [WORK_BITS-1:0]   r_dvs;
    logic [WORK_BITS:0]     r_rem;
    logic                   r_neg;
    logic                   r_zero;
    logic                   r_done;
    logic signed [WORK_BITS-1:0] r_quot;

    logic [WORK_BITS:0]     rem_sh;
    logic                   fits;

    assign rem_sh = {r_rem[WORK_BITS-1:0], r_acc[WORK_BITS-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy      <= 1'b1;
                r_div_phase <= 1'b0;
                r_cnt       <= '0;
                r_acc       <= '0;
                r_mcand     <= i_a[WORK_BITS-1] ? $unsigned(-i_a) : $unsigned(i_a);
                r_mplier    <= i_b[WORK_BITS-1] ? $unsigned(-i_b) : $unsigned(i_b);
                r_dvs       <= i_d[WORK_BITS-1] ? $unsigned(-i_d) : $unsigned(i_d);
                r_neg       <= i_a[WORK_BITS-1] ^ i_b[WORK_BITS-1] ^ i_d[WORK_BITS-1];
                r_zero      <= (i_d == '0);
            end else if (r_busy) begin
                if (!r_div_phase) begin
                    // shift-add multiply
                    if (r_cnt == CNT_BITS'(WORK_BITS)) begin
                        r_div_phase <= 1'b1;
                        r_cnt       <= '0;
                        r_rem       <= '0;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + CNT_BITS'(1);
                    end
                end else begin
                    // restoring divide, quotient shifts into the accumulator
                    if (r_cnt == CNT_BITS'(WORK_BITS)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_zero) begin
                            r_quot <= '0;
                        end else if (r_neg) begin
                            r_quot <= -$signed(r_acc);
                        end else begin
                            r_quot <= $signed(r_acc);
                        end
                    end else begin
                        r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
                        r_acc <= {r_acc[WORK_BITS-2:0], fits};
                        r_cnt <= r_cnt + CNT_BITS'(1);
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: sv/crz_dp.sv
module crz_dp import crz_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_finish_x,
    input  logic signed [COORD_BITS-1:0]  i_finish_y,
    input  logic [COLOR_BITS-1:0]         i_line_color,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_pixel_valid,
    output logic signed [COORD_BITS-1:0]  o_pixel_x,
    output logic signed [COORD_BITS-1:0]  o_pixel_y,
    output logic [COLOR_BITS-1:0]         o_pixel_color,
    output logic                          o_last_pixel,
    output logic                          o_line_rejected
);

    logic [CFG_BITS-1:0] r_w, r_h;

    // clip working set
    logic signed [WORK_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [COLOR_BITS-1:0]       r_color_in;

    // line state
    logic                         r_active, r_first;
    t_mode                        r_mode;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_tx, r_ty;
    logic signed [DEC_BITS-1:0]   r_dec, r_se, r_sd;
    logic [COLOR_BITS-1:0]        r_color;

    // output register
    logic                         r_ov, r_pv, r_last, r_rej;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [COLOR_BITS-1:0]        r_pc;

    logic signed [WORK_BITS-1:0] w_ext, h_ext;
    logic signed [WORK_BITS-1:0] md_a, md_b, md_d, quot;
    logic                        md_done;
    logic                        op_cond;

    assign w_ext = $signed({{(WORK_BITS-CFG_BITS){1'b0}}, r_w});
    assign h_ext = $signed({{(WORK_BITS-CFG_BITS){1'b0}}, r_h});

    always_comb begin
        md_a    = r_y1;
        op_cond = 1'b0;
        unique case (i_cmd.op)
            OP_TOP_1:    begin md_a = r_y1;         op_cond = r_y1 < 0;      end
            OP_TOP_2:    begin md_a = r_y2;         op_cond = r_y2 < 0;      end
            OP_BOTTOM_1: begin md_a = h_ext - r_y1; op_cond = r_y1 >= h_ext; end
            OP_BOTTOM_2: begin md_a = h_ext - r_y2; op_cond = r_y2 >= h_ext; end
            OP_LEFT_1:   begin md_a = r_x1;         op_cond = r_x1 < 0;      end
            OP_LEFT_2:   begin md_a = r_x2;         op_cond = r_x2 < 0;      end
            OP_RIGHT_1:  begin md_a = w_ext - r_x1; op_cond = r_x1 >= w_ext; end
            default:     begin md_a = w_ext - r_x2; op_cond = r_x2 >= w_ext; end
        endcase
        if (i_cmd.op[2]) begin
            md_b = r_y1 - r_y2;
            md_d = r_x2 - r_x1;
        end else begin
            md_b = r_x1 - r_x2;
            md_d = r_y2 - r_y1;
        end
    end

    crz_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_quot  (quot)
    );

    // reject / inside tests on the raw endpoints
    logic signed [WORK_BITS-1:0] ax1, ay1, ax2, ay2;
    assign ax1 = WORK_BITS'(i_start_x);
    assign ay1 = WORK_BITS'(i_start_y);
    assign ax2 = WORK_BITS'(i_finish_x);
    assign ay2 = WORK_BITS'(i_finish_y);

    logic reject_cond, inside_cond;
    assign reject_cond = (r_y1 < 0 && r_y2 < 0) || (r_y1 >= h_ext && r_y2 >= h_ext) ||
                         (r_x1 < 0 && r_x2 < 0) || (r_x1 >= w_ext && r_x2 >= w_ext);
    assign inside_cond = r_x1 >= 0 && r_x1 < w_ext && r_y1 >= 0 && r_y1 < h_ext &&
                         r_x2 >= 0 && r_x2 < w_ext && r_y2 >= 0 && r_y2 < h_ext;

    // line setup after clipping
    logic signed [COORD_BITS-1:0] s1x, s1y, s2x, s2y, ex1, ey1, ex2, ey2;
    logic signed [DIFF_BITS-1:0]  dx, dy;
    logic signed [DEC_BITS-1:0]   dx_e, dy_e;
    t_mode                        f_mode;
    logic signed [DEC_BITS-1:0]   f_dec, f_se, f_sd;
    logic signed [COORD_BITS-1:0] f_cy, f_ty;

    always_comb begin
        s1x = sat_coord(r_x1);
        s1y = sat_coord(r_y1);
        s2x = sat_coord(r_x2);
        s2y = sat_coord(r_y2);
        if (s1x > s2x) begin
            ex1 = s2x; ey1 = s2y; ex2 = s1x; ey2 = s1y;
        end else begin
            ex1 = s1x; ey1 = s1y; ex2 = s2x; ey2 = s2y;
        end
        dx   = DIFF_BITS'(ex2) - DIFF_BITS'(ex1);
        dy   = DIFF_BITS'(ey2) - DIFF_BITS'(ey1);
        dx_e = DEC_BITS'(dx);
        dy_e = DEC_BITS'(dy);
        f_dec = '0;
        f_se  = '0;
        f_sd  = '0;
        f_cy  = ey1;
        f_ty  = ey2;
        if (dx == '0) begin
            f_mode = MODE_VERT;
            if (ey2 < ey1) begin
                f_cy = ey2;
                f_ty = ey1;
            end
        end else if (dy == '0) begin
            f_mode = MODE_HORZ;
        end else if (dy > 0) begin
            if (dy <= dx) begin
                f_mode = MODE_PFLAT;
                f_dec  = (dy_e <<< 1) - dx_e;
                f_se   = dy_e <<< 1;
                f_sd   = (dy_e - dx_e) <<< 1;
            end else begin
                f_mode = MODE_PSTEEP;
                f_dec  = (dx_e <<< 1) - dy_e;
                f_se   = dx_e <<< 1;
                f_sd   = (dx_e - dy_e) <<< 1;
            end
        end else begin
            if (-dy <= dx) begin
                f_mode = MODE_NFLAT;
                f_dec  = -(dy_e <<< 1) - dx_e;
                f_se   = -(dy_e <<< 1);
                f_sd   = -((dy_e + dx_e) <<< 1);
            end else begin
                f_mode = MODE_NSTEEP;
                f_dec  = (dx_e <<< 1) + dy_e;
                f_se   = dx_e <<< 1;
                f_sd   = (dx_e + dy_e) <<< 1;
            end
        end
    end

    // one pixel step
    logic signed [COORD_BITS-1:0] p_cx, p_cy;
    logic signed [DEC_BITS-1:0]   p_dec;
    logic                         p_diag, p_last;

    always_comb begin
        p_cx   = r_cx;
        p_cy   = r_cy;
        p_dec  = r_dec;
        p_diag = r_dec > 0;
        if (!r_first) begin
            unique case (r_mode)
                MODE_VERT: p_cy = r_cy + COORD_BITS'(1);
                MODE_HORZ: p_cx = r_cx + COORD_BITS'(1);
                MODE_PFLAT: begin
                    p_dec = r_dec + (p_diag ? r_sd : r_se);
                    p_cx  = r_cx + COORD_BITS'(1);
                    p_cy  = r_cy + COORD_BITS'(p_diag);
                end
                MODE_PSTEEP: begin
                    p_dec = r_dec + (p_diag ? r_sd : r_se);
                    p_cy  = r_cy + COORD_BITS'(1);
                    p_cx  = r_cx + COORD_BITS'(p_diag);
                end
                MODE_NFLAT: begin
                    p_dec = r_dec + (p_diag ? r_sd : r_se);
                    p_cx  = r_cx + COORD_BITS'(1);
                    p_cy  = r_cy - COORD_BITS'(p_diag);
                end
                default: begin
                    p_dec = r_dec + (p_diag ? r_sd : r_se);
                    p_cy  = r_cy - COORD_BITS'(1);
                    p_cx  = r_cx + COORD_BITS'(p_diag);
                end
            endcase
        end
        if (r_mode == MODE_HORZ || r_mode == MODE_PFLAT || r_mode == MODE_NFLAT) begin
            p_last = p_cx == r_tx;
        end else begin
            p_last = p_cy == r_ty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= '0;
            r_h      <= '0;
            r_active <= 1'b0;
            r_first  <= 1'b0;
            r_mode   <= MODE_VERT;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  r_w <= i_cfg_data;
                    default:          r_h <= i_cfg_data;
                endcase
            end

            // load a new result, else drop the held one once it is transferred
            if (i_cmd.reject || i_cmd.finish || i_cmd.step) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end

            if (i_cmd.load_start) begin
                r_x1       <= ax1;
                r_y1       <= ay1;
                r_x2       <= ax2;
                r_y2       <= ay2;
                r_color_in <= i_line_color;
                r_active   <= 1'b0;
                r_first    <= 1'b0;
            end

            if (i_cmd.apply) begin
                unique case (i_cmd.op)
                    OP_TOP_1:    begin r_x1 <= r_x1 + quot; r_y1 <= '0; end
                    OP_TOP_2:    begin r_x2 <= r_x2 + quot; r_y2 <= '0; end
                    OP_BOTTOM_1: begin r_x1 <= r_x1 - quot; r_y1 <= h_ext - 1; end
                    OP_BOTTOM_2: begin r_x2 <= r_x2 - quot; r_y2 <= h_ext - 1; end
                    OP_LEFT_1:   begin r_y1 <= r_y1 + quot; r_x1 <= '0; end
                    OP_LEFT_2:   begin r_y2 <= r_y2 + quot; r_x2 <= '0; end
                    OP_RIGHT_1:  begin r_y1 <= r_y1 - quot; r_x1 <= w_ext - 1; end
                    default:     begin r_y2 <= r_y2 - quot; r_x2 <= w_ext - 1; end
                endcase
            end

            if (i_cmd.reject) begin
                r_pv   <= 1'b0;
                r_px   <= '0;
                r_py   <= '0;
                r_pc   <= '0;
                r_last <= 1'b0;
                r_rej  <= 1'b1;
            end

            if (i_cmd.finish) begin
                r_mode   <= f_mode;
                r_cx     <= ex1;
                r_cy     <= f_cy;
                r_tx     <= ex2;
                r_ty     <= f_ty;
                r_dec    <= f_dec;
                r_se     <= f_se;
                r_sd     <= f_sd;
                r_color  <= r_color_in;
                r_active <= 1'b1;
                r_first  <= 1'b1;
                r_pv     <= 1'b0;
                r_px     <= '0;
                r_py     <= '0;
                r_pc     <= '0;
                r_last   <= 1'b0;
                r_rej    <= 1'b0;
            end

            if (i_cmd.step) begin
                r_rej <= 1'b0;
                if (r_active) begin
                    r_first <= 1'b0;
                    r_cx    <= p_cx;
                    r_cy    <= p_cy;
                    r_dec   <= p_dec;
                    if (p_last) begin
                        r_active <= 1'b0;
                    end
                    r_pv   <= 1'b1;
                    r_px   <= p_cx;
                    r_py   <= p_cy;
                    r_pc   <= r_color;
                    r_last <= p_last;
                end else begin
                    r_pv   <= 1'b0;
                    r_px   <= '0;
                    r_py   <= '0;
                    r_pc   <= '0;
                    r_last <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_status.reject_cond = reject_cond;
        o_status.inside_cond = inside_cond;
        o_status.op_cond     = op_cond;
        o_status.md_done     = md_done;
        o_status.out_free    = !r_ov || i_out_ready;
    end

    assign o_out_valid     = r_ov;
    assign o_pixel_valid   = r_pv;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_color   = r_pc;
    assign o_last_pixel    = r_last;
    assign o_line_rejected = r_rej;

endmodule

FILE: sv/crz_ctrl.sv
module crz_ctrl import crz_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_TEST   = 6'b000100,
        S_CALC   = 6'b001000,
        S_FINISH = 6'b010000,
        S_REJECT = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [OP_BITS-1:0] r_op, n_op;
    logic               take;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        o_cmd            = '0;
        o_cmd.op         = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_in_cmd == CMD_STEP) begin
                        o_cmd.step = 1'b1;
                    end else begin
                        o_cmd.load_start = 1'b1;
                        n_state          = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_op = OP_TOP_1;
                priority if (i_status.reject_cond) begin
                    n_state = S_REJECT;
                end else if (i_status.inside_cond) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.op_cond) begin
                    o_cmd.op_start = 1'b1;
                    n_state        = S_CALC;
                end else if (r_op == OP_RIGHT_2) begin
                    n_state = S_FINISH;
                end else begin
                    n_op = r_op + OP_BITS'(1);
                end
            end
            S_CALC: begin
                if (i_status.md_done) begin
                    o_cmd.apply = 1'b1;
                    if (r_op == OP_RIGHT_2) begin
                        n_state = S_FINISH;
                    end else begin
                        n_op    = r_op + OP_BITS'(1);
                        n_state = S_TEST;
                    end
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REJECT: begin
                if (i_status.out_free) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TOP_1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

FILE: sv/clipped_line_rasterizer.sv
// Clipped line rasteriser.
// Input channel i_in: cmd = start transfers two endpoints and a colour; the line
// is rejected when it lies wholly beyond one image edge, otherwise clipped to the
// image set through the configuration port, ordered left to right and set up
// for the midpoint walk. cmd = step transfers ask for the next pixel.
// Output channel o_out: exactly one result per input transfer, in order. A start
// result carries no pixel and only reports line_rejected; a step result carries
// the pixel, the line colour and last_pixel, or all zero when no line is active.
// Step items: one per cycle while o_out.ready stays high, result registered in the
// cycle after the transfer. Start items: the endpoints are loaded and checked, and
// the result follows the check directly when the line is rejected or lies inside;
// otherwise each clip is tested in order and each one that applies runs the serial
// multiply-divide unit (one bit per cycle); no item is taken meanwhile.
// The output register holds a result while o_out.ready is low; a new item is taken
// in the same cycle the held result is transferred. Reset clears the image size,
// the active line and the output valid flag. Write image_width / image_height
// (index 0 / 1) only while the block is idle.
module clipped_line_rasterizer import crz_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    crz_in_if.sink                  i_in,
    crz_out_if.source               o_out
);

    t_cmd    cmd;
    t_status status;

    crz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    crz_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_start_x       (i_in.start_x),
        .i_start_y       (i_in.start_y),
        .i_finish_x      (i_in.finish_x),
        .i_finish_y      (i_in.finish_y),
        .i_line_color    (i_in.line_color),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_pixel_valid   (o_out.pixel_valid),
        .o_pixel_x       (o_out.pixel_x),
        .o_pixel_y       (o_out.pixel_y),
        .o_pixel_color   (o_out.pixel_color),
        .o_last_pixel    (o_out.last_pixel),
        .o_line_rejected (o_out.line_rejected)
    );

endmodule
